>>> design/hbp_pkg.sv
package hbp_pkg;

    // default table sizes in index bits
    localparam int MAX_BIMODAL_BITS_DEF = 12;
    localparam int MAX_GSHARE_BITS_DEF  = 12;
    localparam int MAX_CHOOSER_BITS_DEF = 12;

    // field and port widths
    localparam int ADDR_W      = 32;
    localparam int PC_W        = ADDR_W - 2;
    localparam int CNT_W       = 32;
    localparam int CTR_W       = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 72;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 4;
    localparam int BITS_W      = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PREDICTOR_SELECT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIMODAL_INDEX_BITS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GSHARE_INDEX_BITS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HISTORY_BITS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHOOSER_INDEX_BITS = 3'd4;

    // predictor modes; any other code runs the tournament
    localparam logic [1:0] MODE_BIMODAL = 2'd0;
    localparam logic [1:0] MODE_GSHARE  = 2'd1;
    localparam logic [1:0] MODE_HYBRID  = 2'd2;

    // register reset values
    localparam logic [3:0] BIMODAL_BITS_RST = 4'd12;
    localparam logic [3:0] GSHARE_BITS_RST  = 4'd12;
    localparam logic [3:0] HISTORY_BITS_RST = 4'd8;
    localparam logic [3:0] CHOOSER_BITS_RST = 4'd12;

    // two-bit counter values
    localparam logic [CTR_W-1:0] CTR_MIN         = 2'd0;
    localparam logic [CTR_W-1:0] CTR_WEAK_BIMODAL = 2'd1;
    localparam logic [CTR_W-1:0] CTR_WEAK_TAKEN  = 2'd2;
    localparam logic [CTR_W-1:0] CTR_MAX         = 2'd3;

    typedef struct packed {
        logic [1:0] predictor_select;
        logic [3:0] bimodal_index_bits;
        logic [3:0] gshare_index_bits;
        logic [3:0] history_bits;
        logic [3:0] chooser_index_bits;
    } cfg_t;

    typedef struct packed {
        logic             pred;
        logic             mispred;
        logic             used_gshare;
        logic             bm_we;
        logic             gs_we;
        logic             ch_we;
        logic [CTR_W-1:0] bm_new;
        logic [CTR_W-1:0] gs_new;
        logic [CTR_W-1:0] ch_new;
    } train_t;

    // saturating two-bit counter step
    function automatic logic [CTR_W-1:0] ctr_step(input logic [CTR_W-1:0] ctr,
                                                  input logic up);
        logic [CTR_W-1:0] res;
        res = ctr;
        if (up) begin
            if (ctr != CTR_MAX) res = ctr + 2'd1;
        end else begin
            if (ctr != CTR_MIN) res = ctr - 2'd1;
        end
        return res;
    endfunction

endpackage

>>> design/hbp_ram.sv
module hbp_ram
    #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
    ) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/hbp_index.sv
module hbp_index
    import hbp_pkg::*;
    #(
    parameter int BW = MAX_BIMODAL_BITS_DEF,
    parameter int GW = MAX_GSHARE_BITS_DEF,
    parameter int CW = MAX_CHOOSER_BITS_DEF
    ) (
    input  cfg_t            cfg,
    input  logic [PC_W-1:0] pc,
    input  logic            taken,
    input  logic [GW-1:0]   history,
    output logic [BW-1:0]   bm_idx,
    output logic [GW-1:0]   gs_idx,
    output logic [CW-1:0]   ch_idx,
    output logic [GW-1:0]   history_next
);

    localparam logic [BITS_W-1:0] BMAX = BITS_W'(BW);
    localparam logic [BITS_W-1:0] GMAX = BITS_W'(GW);
    localparam logic [BITS_W-1:0] CMAX = BITS_W'(CW);

    logic [BITS_W-1:0] b_n, g_n, c_n, h_raw, h_n, x_n;
    logic [BW-1:0]     b_mask;
    logic [GW-1:0]     g_mask, h_mask, m, y;
    logic [CW-1:0]     c_mask;
    logic [GW:0]       hist_ext;

    // clamp the index widths to 1..max and the history to the gshare width
    always_comb begin
        b_n = {1'b0, cfg.bimodal_index_bits};
        if (b_n == '0) b_n = BITS_W'(1);
        else if (b_n > BMAX) b_n = BMAX;
        g_n = {1'b0, cfg.gshare_index_bits};
        if (g_n == '0) g_n = BITS_W'(1);
        else if (g_n > GMAX) g_n = GMAX;
        c_n = {1'b0, cfg.chooser_index_bits};
        if (c_n == '0) c_n = BITS_W'(1);
        else if (c_n > CMAX) c_n = CMAX;
        h_raw = {1'b0, cfg.history_bits};
        h_n   = (h_raw > g_n) ? g_n : h_raw;
        x_n   = g_n - h_n;
    end

    // low-bit masks
    always_comb begin
        for (int i = 0; i < BW; i++) b_mask[i] = (BITS_W'(i) < b_n);
        for (int i = 0; i < GW; i++) g_mask[i] = (BITS_W'(i) < g_n);
        for (int i = 0; i < GW; i++) h_mask[i] = (BITS_W'(i) < h_n);
        for (int i = 0; i < CW; i++) c_mask[i] = (BITS_W'(i) < c_n);
    end

    // history folds into the top h bits of the gshare index
    always_comb begin
        m      = pc[GW-1:0] & g_mask;
        y      = history & h_mask;
        gs_idx = (m ^ (y << x_n)) & g_mask;
        bm_idx = pc[BW-1:0] & b_mask;
        ch_idx = pc[CW-1:0] & c_mask;
    end

    // newest outcome is or-ed into bit h-1 over the shifted history;
    // bimodal mode and zero length keep it
    always_comb begin
        hist_ext = {1'b0, history};
        if (cfg.predictor_select != MODE_BIMODAL && h_n != '0) begin
            for (int i = 0; i < GW; i++) begin
                if (BITS_W'(i) < h_n) begin
                    history_next[i] = (BITS_W'(i) == h_n - BITS_W'(1))
                                    ? (taken | hist_ext[i+1]) : hist_ext[i+1];
                end else begin
                    history_next[i] = 1'b0;
                end
            end
        end else begin
            history_next = history;
        end
    end

endmodule

>>> design/hbp_train.sv
module hbp_train
    import hbp_pkg::*;
    (
    input  logic [1:0]       mode,
    input  logic             taken,
    input  logic [CTR_W-1:0] bm_ctr,
    input  logic [CTR_W-1:0] gs_ctr,
    input  logic [CTR_W-1:0] ch_ctr,
    output train_t           res
);

    logic pred_bm, pred_gs, hybrid, chose_gs;

    always_comb begin
        pred_bm  = bm_ctr[1];
        pred_gs  = gs_ctr[1];
        hybrid   = (mode != MODE_BIMODAL) && (mode != MODE_GSHARE);
        chose_gs = hybrid ? ch_ctr[1] : (mode == MODE_GSHARE);

        res.pred        = chose_gs ? pred_gs : pred_bm;
        res.mispred     = res.pred != taken;
        res.used_gshare = chose_gs;

        // only the table that supplied the prediction learns
        res.bm_we  = !chose_gs;
        res.gs_we  = chose_gs;
        res.bm_new = ctr_step(bm_ctr, taken);
        res.gs_new = ctr_step(gs_ctr, taken);

        // chooser leans toward whichever predictor alone was right
        res.ch_we  = hybrid;
        res.ch_new = ch_ctr;
        if (pred_gs == taken && pred_bm != taken) begin
            res.ch_new = ctr_step(ch_ctr, 1'b1);
        end else if (pred_gs != taken && pred_bm == taken) begin
            res.ch_new = ctr_step(ch_ctr, 1'b0);
        end
    end

endmodule

>>> design/hybrid_branch_predictor.sv
// result path: a result enters the output register in S_CALC, or through the hold register
// in S_HOLD while the output stalls; a new branch is taken only back in S_IDLE, after the
// read-modify-write of the counter tables (registered read, write-back in S_CALC)
// reset: synchronous active low; afterwards a clearing pass over 2**max(index bits) addresses
// (4096 by default) fills the tables while s_tready stays low; config writes are taken
module hybrid_branch_predictor
    import hbp_pkg::*;
    #(
    parameter int MAX_BIMODAL_BITS = MAX_BIMODAL_BITS_DEF,
    parameter int MAX_GSHARE_BITS  = MAX_GSHARE_BITS_DEF,
    parameter int MAX_CHOOSER_BITS = MAX_CHOOSER_BITS_DEF
    ) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // branch_address[31:0], taken[32], zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // predicted_taken[0], mispredicted[1],
                                              // used_gshare[2], branch_total[34:3],
                                              // mispredict_total[66:35], zero pad
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int BW    = MAX_BIMODAL_BITS;
    localparam int GW    = MAX_GSHARE_BITS;
    localparam int CW    = MAX_CHOOSER_BITS;
    localparam int BGW   = (BW > GW) ? BW : GW;
    localparam int CLR_W = (BGW > CW) ? BGW : CW;
    localparam int PAD_W = OUT_TDATA_W - 3 - 2 * CNT_W;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_CALC, S_HOLD} state_t;

    state_t             state_reg;
    cfg_t               cfg_reg;
    logic [CLR_W-1:0]   clr_addr_reg;
    logic [GW-1:0]      history_reg;
    logic [BW-1:0]      bm_idx_reg;
    logic [GW-1:0]      gs_idx_reg;
    logic [CW-1:0]      ch_idx_reg;
    logic               taken_reg;
    logic [CNT_W-1:0]   branch_total_reg, branch_total_next;
    logic [CNT_W-1:0]   mispredict_total_reg, mispredict_total_next;
    logic               m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, hold_reg, result;

    logic [BW-1:0]      bm_idx;
    logic [GW-1:0]      gs_idx;
    logic [CW-1:0]      ch_idx;
    logic [GW-1:0]      history_next;
    logic [CTR_W-1:0]   bm_q, gs_q, ch_q;
    train_t             trn;

    logic               clearing, calc;
    logic               out_load;
    logic               bm_we, gs_we, ch_we;
    logic [BW-1:0]      bm_waddr;
    logic [GW-1:0]      gs_waddr;
    logic [CW-1:0]      ch_waddr;
    logic [CTR_W-1:0]   bm_wdata, gs_wdata, ch_wdata;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // output register loads from the training path or the hold register
    assign out_load = (calc && (!m_tvalid_reg || m_tready))
                   || (state_reg == S_HOLD && m_tready);

    // index generation from the incoming transaction
    hbp_index #(.BW(BW), .GW(GW), .CW(CW)) u_index (
        .cfg          (cfg_reg),
        .pc           (s_tdata[ADDR_W-1:2]),
        .taken        (s_tdata[ADDR_W]),
        .history      (history_reg),
        .bm_idx       (bm_idx),
        .gs_idx       (gs_idx),
        .ch_idx       (ch_idx),
        .history_next (history_next)
    );

    // prediction and counter training from the table reads
    hbp_train u_train (
        .mode   (cfg_reg.predictor_select),
        .taken  (taken_reg),
        .bm_ctr (bm_q),
        .gs_ctr (gs_q),
        .ch_ctr (ch_q),
        .res    (trn)
    );

    // table write ports: clearing pass or write-back
    always_comb begin
        clearing = (state_reg == S_CLEAR);
        calc     = (state_reg == S_CALC);
        if (clearing) begin
            bm_we    = 1'b1;
            gs_we    = 1'b1;
            ch_we    = 1'b1;
            bm_waddr = clr_addr_reg[BW-1:0];
            gs_waddr = clr_addr_reg[GW-1:0];
            ch_waddr = clr_addr_reg[CW-1:0];
            bm_wdata = CTR_WEAK_TAKEN;
            gs_wdata = CTR_WEAK_TAKEN;
            ch_wdata = CTR_WEAK_BIMODAL;
        end else begin
            bm_we    = calc && trn.bm_we;
            gs_we    = calc && trn.gs_we;
            ch_we    = calc && trn.ch_we;
            bm_waddr = bm_idx_reg;
            gs_waddr = gs_idx_reg;
            ch_waddr = ch_idx_reg;
            bm_wdata = trn.bm_new;
            gs_wdata = trn.gs_new;
            ch_wdata = trn.ch_new;
        end
    end

    hbp_ram #(.WIDTH(CTR_W), .DEPTH(1 << BW)) u_bimodal_ram (
        .aclk  (aclk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_idx),
        .rdata (bm_q)
    );

    hbp_ram #(.WIDTH(CTR_W), .DEPTH(1 << GW)) u_gshare_ram (
        .aclk  (aclk),
        .we    (gs_we),
        .waddr (gs_waddr),
        .wdata (gs_wdata),
        .raddr (gs_idx),
        .rdata (gs_q)
    );

    hbp_ram #(.WIDTH(CTR_W), .DEPTH(1 << CW)) u_chooser_ram (
        .aclk  (aclk),
        .we    (ch_we),
        .waddr (ch_waddr),
        .wdata (ch_wdata),
        .raddr (ch_idx),
        .rdata (ch_q)
    );

    // saturating totals and the packed result
    always_comb begin
        branch_total_next = branch_total_reg;
        if (branch_total_reg != '1) branch_total_next = branch_total_reg + CNT_W'(1);
        mispredict_total_next = mispredict_total_reg;
        if (trn.mispred && mispredict_total_reg != '1) begin
            mispredict_total_next = mispredict_total_reg + CNT_W'(1);
        end
        result = {PAD_W'(0), mispredict_total_next, branch_total_next,
                  trn.used_gshare, trn.mispred, trn.pred};
    end

    // control, config registers and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg                  <= S_CLEAR;
            clr_addr_reg               <= '0;
            cfg_reg.predictor_select   <= MODE_HYBRID;
            cfg_reg.bimodal_index_bits <= BIMODAL_BITS_RST;
            cfg_reg.gshare_index_bits  <= GSHARE_BITS_RST;
            cfg_reg.history_bits       <= HISTORY_BITS_RST;
            cfg_reg.chooser_index_bits <= CHOOSER_BITS_RST;
            history_reg                <= '0;
            branch_total_reg           <= '0;
            mispredict_total_reg       <= '0;
            m_tvalid_reg               <= 1'b0;
        end else begin
            // config writes
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_PREDICTOR_SELECT:   cfg_reg.predictor_select   <= cfg_wdata[1:0];
                    REG_BIMODAL_INDEX_BITS: cfg_reg.bimodal_index_bits <= cfg_wdata;
                    REG_GSHARE_INDEX_BITS:  cfg_reg.gshare_index_bits  <= cfg_wdata;
                    REG_HISTORY_BITS:       cfg_reg.history_bits       <= cfg_wdata;
                    REG_CHOOSER_INDEX_BITS: cfg_reg.chooser_index_bits <= cfg_wdata;
                    default: ;
                endcase
            end

            // result valid: set on a load, cleared once taken
            if (out_load) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                S_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + CLR_W'(1);
                    if (clr_addr_reg == '1) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    // tables are read at the indexes of this transaction
                    if (s_tvalid) begin
                        bm_idx_reg  <= bm_idx;
                        gs_idx_reg  <= gs_idx;
                        ch_idx_reg  <= ch_idx;
                        taken_reg   <= s_tdata[ADDR_W];
                        history_reg <= history_next;
                        state_reg   <= S_CALC;
                    end
                end
                S_CALC: begin
                    branch_total_reg     <= branch_total_next;
                    mispredict_total_reg <= mispredict_total_next;
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= result;
                        state_reg    <= S_IDLE;
                    end else begin
                        hold_reg  <= result;
                        state_reg <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (m_tready) begin
                        m_tdata_reg  <= hold_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> design/hbp_checker.sv
module hbp_checker
    import hbp_pkg::*;
    (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata
);

    logic             in_acc, out_acc;
    logic [1:0]       pend_reg;
    logic [CNT_W-1:0] last_bt_reg, last_mt_reg;
    logic [CNT_W-1:0] bt, mt;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;
    assign bt      = m_tdata[3 +: CNT_W];
    assign mt      = m_tdata[3 + CNT_W +: CNT_W];

    // transactions in flight and totals of the last result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= '0;
            last_bt_reg <= '0;
            last_mt_reg <= '0;
        end else begin
            pend_reg <= pend_reg + {1'b0, in_acc} - {1'b0, out_acc};
            if (out_acc) begin
                last_bt_reg <= bt;
                last_mt_reg <= mt;
            end
        end
    end

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no result without an accepted branch
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pend_reg != 2'd0)
        else $error("result without a pending branch");

    // branch total steps by one per result, sticking at all ones
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc |-> (bt == last_bt_reg + CNT_W'(1)) || (bt == '1 && last_bt_reg == '1))
        else $error("branch total out of sequence");

    // mispredict total follows the mispredicted flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc |-> (mt == last_mt_reg + CNT_W'(m_tdata[1]))
                 || (mt == '1 && last_mt_reg == '1))
        else $error("mispredict total out of sequence");

    // mispredictions never outnumber branches
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc |-> mt <= bt)
        else $error("mispredict total above branch total");

endmodule

bind hybrid_branch_predictor hbp_checker u_hbp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/sv/hybrid_branch_predictor_tb.sv
module hybrid_branch_predictor_tb;
    import hbp_pkg::*;

    localparam int BM_DEPTH    = 1 << MAX_BIMODAL_BITS_DEF;
    localparam int GS_DEPTH    = 1 << MAX_GSHARE_BITS_DEF;
    localparam int CH_DEPTH    = 1 << MAX_CHOOSER_BITS_DEF;
    localparam int STALL_LIMIT = 20000;
    localparam int POOL_SIZE   = 8;

    // register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic              taken;
    } branch_t;

    typedef struct packed {
        logic             predicted_taken;
        logic             mispredicted;
        logic             used_gshare;
        logic [CNT_W-1:0] branch_total;
        logic [CNT_W-1:0] mispredict_total;
    } outcome_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    branch_t  branch_q[$];
    outcome_t outcome_q[$];
    int       error_count  = 0;
    int       stall_cycles = 0;
    logic     steady       = 1'b0;

    // predictor state mirrored by the testbench
    logic [CTR_W-1:0] bimodal_tab[BM_DEPTH];
    logic [CTR_W-1:0] gshare_tab[GS_DEPTH];
    logic [CTR_W-1:0] chooser_tab[CH_DEPTH];
    int unsigned      ghist;
    logic [CNT_W-1:0] branch_cnt;
    logic [CNT_W-1:0] mispredict_cnt;
    cfg_t             mdl_cfg;

    hybrid_branch_predictor u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned bit_mask(input int unsigned n);
        return (1 << n) - 1;
    endfunction

    // zero reads as one, oversize saturates to the table size
    function automatic int unsigned clamp_width(input logic [3:0] v, input int unsigned maxv);
        if (v == 4'd0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic logic [CTR_W-1:0] saturate_step(input logic [CTR_W-1:0] c, input logic up);
        if (up) return (c == CTR_MAX) ? c : c + 2'd1;
        return (c == CTR_MIN) ? c : c - 2'd1;
    endfunction

    task automatic reset_model();
        for (int i = 0; i < BM_DEPTH; i++) bimodal_tab[i] = CTR_WEAK_TAKEN;
        for (int i = 0; i < GS_DEPTH; i++) gshare_tab[i] = CTR_WEAK_TAKEN;
        for (int i = 0; i < CH_DEPTH; i++) chooser_tab[i] = CTR_WEAK_BIMODAL;
        ghist          = 0;
        branch_cnt     = '0;
        mispredict_cnt = '0;
        mdl_cfg.predictor_select   = MODE_HYBRID;
        mdl_cfg.bimodal_index_bits = BIMODAL_BITS_RST;
        mdl_cfg.gshare_index_bits  = GSHARE_BITS_RST;
        mdl_cfg.history_bits       = HISTORY_BITS_RST;
        mdl_cfg.chooser_index_bits = CHOOSER_BITS_RST;
    endtask

    // lookup, train and count one resolved branch
    function automatic outcome_t predict_branch(input logic [ADDR_W-1:0] addr,
                                                input logic taken);
        int unsigned pc, bi, gi, ci, g, h, m, x;
        logic        use_bm, use_gs, hybrid, pred_bm, pred_gs, pred, chose_gs;
        outcome_t    res;
        pc      = addr[ADDR_W-1:2];
        use_bm  = (mdl_cfg.predictor_select == MODE_BIMODAL);
        use_gs  = (mdl_cfg.predictor_select == MODE_GSHARE);
        hybrid  = !use_bm && !use_gs;
        bi      = 0;
        gi      = 0;
        pred_bm = 1'b0;
        pred_gs = 1'b0;

        if (!use_gs) begin
            bi = pc & bit_mask(clamp_width(mdl_cfg.bimodal_index_bits, MAX_BIMODAL_BITS_DEF));
            pred_bm = bimodal_tab[bi] >= CTR_WEAK_TAKEN;
        end

        // history xor goes into the top h bits of the gshare index
        if (!use_bm) begin
            g = clamp_width(mdl_cfg.gshare_index_bits, MAX_GSHARE_BITS_DEF);
            h = (mdl_cfg.history_bits > g) ? g : mdl_cfg.history_bits;
            m = pc & bit_mask(g);
            if (h == 0) begin
                gi = m;
            end else begin
                x     = g - h;
                gi    = ((((m >> x) ^ (ghist & bit_mask(h))) << x) | (m & bit_mask(x)))
                        & bit_mask(g);
                ghist = ((ghist >> 1) | (int'(taken) << (h - 1))) & bit_mask(h);
            end
            pred_gs = gshare_tab[gi] >= CTR_WEAK_TAKEN;
        end

        // chooser moves toward the predictor that alone was right
        if (hybrid) begin
            ci = pc & bit_mask(clamp_width(mdl_cfg.chooser_index_bits, MAX_CHOOSER_BITS_DEF));
            chose_gs = chooser_tab[ci] >= CTR_WEAK_TAKEN;
            if (pred_gs == taken && pred_bm != taken)
                chooser_tab[ci] = saturate_step(chooser_tab[ci], 1'b1);
            else if (pred_gs != taken && pred_bm == taken)
                chooser_tab[ci] = saturate_step(chooser_tab[ci], 1'b0);
        end else begin
            chose_gs = use_gs;
        end

        if (chose_gs) begin
            pred = pred_gs;
            gshare_tab[gi] = saturate_step(gshare_tab[gi], taken);
        end else begin
            pred = pred_bm;
            bimodal_tab[bi] = saturate_step(bimodal_tab[bi], taken);
        end

        if (branch_cnt != '1) branch_cnt++;
        if (pred != taken && mispredict_cnt != '1) mispredict_cnt++;

        res.predicted_taken  = pred;
        res.mispredicted     = (pred != taken);
        res.used_gshare      = chose_gs;
        res.branch_total     = branch_cnt;
        res.mispredict_total = mispredict_cnt;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // driver: next branch transaction from the pending queue
    always @(posedge aclk) begin : driver
        branch_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (branch_q.size() != 0 && (steady || $urandom_range(99) >= 11)) begin
                nxt = branch_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {{(IN_TDATA_W-ADDR_W-1){1'b0}}, nxt.taken, nxt.addr};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: check results, then track config writes and accepted branches
    always @(posedge aclk) begin : monitor
        outcome_t want, got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= 11);
            if (m_tvalid && m_tready) begin
                got.predicted_taken  = m_tdata[0];
                got.mispredicted     = m_tdata[1];
                got.used_gshare      = m_tdata[2];
                got.branch_total     = m_tdata[34:3];
                got.mispredict_total = m_tdata[66:35];
                if (outcome_q.size() == 0) begin
                    $display("%0t: unexpected result transaction 0x%0h", $time, m_tdata);
                    error_count++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("predicted_taken", want.predicted_taken, got.predicted_taken);
                    check_field("mispredicted", want.mispredicted, got.mispredicted);
                    check_field("used_gshare", want.used_gshare, got.used_gshare);
                    check_field("branch_total", want.branch_total, got.branch_total);
                    check_field("mispredict_total", want.mispredict_total,
                                got.mispredict_total);
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_PREDICTOR_SELECT:   mdl_cfg.predictor_select   = cfg_wdata[1:0];
                    REG_BIMODAL_INDEX_BITS: mdl_cfg.bimodal_index_bits = cfg_wdata;
                    REG_GSHARE_INDEX_BITS:  mdl_cfg.gshare_index_bits  = cfg_wdata;
                    REG_HISTORY_BITS:       mdl_cfg.history_bits       = cfg_wdata;
                    REG_CHOOSER_INDEX_BITS: mdl_cfg.chooser_index_bits = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                outcome_q.push_back(predict_branch(s_tdata[ADDR_W-1:0], s_tdata[ADDR_W]));
        end
    end

    // cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) @(negedge aclk);
        $display("hybrid_branch_predictor_tb failed");
        $finish;
    end

    task automatic queue_branch(input logic [ADDR_W-1:0] addr, input logic taken);
        branch_t b;
        b.addr  = addr;
        b.taken = taken;
        branch_q.push_back(b);
    endtask

    // wait until every branch is in and every result is out
    task automatic drain();
        @(negedge aclk);
        while (branch_q.size() != 0 || s_tvalid || outcome_q.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
    endtask

    task automatic close_writes();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // index widths weighted toward the extremes
    function automatic logic [CFG_DATA_W-1:0] random_width();
        int r;
        r = $urandom_range(99);
        if (r < 15) return 4'd0;
        if (r < 30) return 4'd1;
        if (r < 50) return 4'd12;
        if (r < 60) return 4'($urandom_range(15, 13));
        return 4'($urandom_range(11, 2));
    endfunction

    initial begin : stimulus
        logic [ADDR_W-1:0] pool_addr[POOL_SIZE];
        logic [3:0]        pool_pat[POOL_SIZE];
        int                pool_len[POOL_SIZE];
        int                pool_pos[POOL_SIZE];
        int                n, k;

        reset_model();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: hybrid, full tables, history of eight
        @(negedge aclk);
        queue_branch(32'h0000_0000, 1'b0);
        queue_branch(32'h0000_0000, 1'b0);
        queue_branch(32'h0000_0000, 1'b1);
        queue_branch(32'hFFFF_FFFF, 1'b1);
        queue_branch(32'hFFFF_FFFF, 1'b1);
        queue_branch(32'hFFFF_FFFF, 1'b0);
        queue_branch(32'h5555_5557, 1'b1);
        queue_branch(32'hAAAA_AAAA, 1'b0);
        for (int i = 0; i < 4; i++) queue_branch(32'h0000_1000, 1'(i % 2 == 0));
        drain();

        // bimodal alone with a zero width, read as one bit
        write_reg(REG_PREDICTOR_SELECT, CFG_DATA_W'(MODE_BIMODAL));
        write_reg(REG_BIMODAL_INDEX_BITS, 4'd0);
        close_writes();
        queue_branch(32'h0000_0004, 1'b0);
        queue_branch(32'h0000_0008, 1'b0);
        queue_branch(32'hFFFF_FFFC, 1'b1);
        drain();

        // gshare alone with history turned off
        write_reg(REG_PREDICTOR_SELECT, CFG_DATA_W'(MODE_GSHARE));
        write_reg(REG_GSHARE_INDEX_BITS, 4'd1);
        write_reg(REG_HISTORY_BITS, 4'd0);
        close_writes();
        queue_branch(32'h0000_0000, 1'b1);
        queue_branch(32'h0000_0004, 1'b0);
        queue_branch(32'h0000_0000, 1'b1);
        drain();

        // selector code three, oversize bimodal width, zero chooser width, history clamped, stray register
        write_reg(REG_PREDICTOR_SELECT, 4'hF);
        write_reg(REG_BIMODAL_INDEX_BITS, 4'd15);
        write_reg(REG_GSHARE_INDEX_BITS, 4'd4);
        write_reg(REG_HISTORY_BITS, 4'd15);
        write_reg(REG_CHOOSER_INDEX_BITS, 4'd0);
        write_reg(REG_UNUSED_HI, 4'hF);
        close_writes();
        for (int i = 0; i < 3; i++) queue_branch(32'hDEAD_BEEF, 1'b1);
        queue_branch(32'hDEAD_BEEF, 1'b0);
        drain();

        // shorter history drops the older bits
        write_reg(REG_PREDICTOR_SELECT, CFG_DATA_W'(MODE_HYBRID));
        write_reg(REG_GSHARE_INDEX_BITS, 4'd12);
        write_reg(REG_HISTORY_BITS, 4'd2);
        write_reg(REG_CHOOSER_INDEX_BITS, 4'd15);
        close_writes();
        queue_branch(32'h0000_0100, 1'b1);
        queue_branch(32'h0000_0100, 1'b0);
        queue_branch(32'h0000_0104, 1'b1);

        // random phases: patterned branches from a small pool, some noise
        for (int ph = 0; ph < 10; ph++) begin
            drain();
            write_reg(REG_PREDICTOR_SELECT, 4'($urandom_range(15)));
            write_reg(REG_BIMODAL_INDEX_BITS, random_width());
            write_reg(REG_GSHARE_INDEX_BITS, random_width());
            write_reg(REG_HISTORY_BITS, random_width());
            write_reg(REG_CHOOSER_INDEX_BITS, random_width());
            if ($urandom_range(3) == 0)
                write_reg(3'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)),
                          4'($urandom_range(15)));
            close_writes();
            steady = (ph == 4);
            for (int i = 0; i < POOL_SIZE; i++) begin
                pool_addr[i] = $urandom;
                pool_pat[i]  = 4'($urandom_range(15));
                pool_len[i]  = $urandom_range(4, 1);
                pool_pos[i]  = 0;
            end
            n = $urandom_range(120, 80);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(99) < 80) begin
                    k = $urandom_range(POOL_SIZE - 1);
                    queue_branch(pool_addr[k], pool_pat[k][pool_pos[k]]);
                    pool_pos[k] = (pool_pos[k] + 1) % pool_len[k];
                end else begin
                    queue_branch($urandom, 1'($urandom_range(1)));
                end
            end
        end

        drain();
        steady = 1'b0;
        repeat (10) @(negedge aclk);
        if (error_count == 0 && outcome_q.size() == 0) begin
            $display("hybrid_branch_predictor_tb passed");
        end else begin
            $display("hybrid_branch_predictor_tb failed");
        end
        $finish;
    end

endmodule
